@@ sv/ietq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ietq_pkg
// shared types, opcodes and state encoding for the edge timestamp queue
// ----------------------------------------------------------------------------
package ietq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int RING_SLOTS  = 8;

	typedef enum logic [2:0] {
		OP_POLL     = 3'd0,
		OP_FRAME    = 3'd1,
		OP_SUBSTEP  = 3'd2,
		OP_RESET    = 3'd3,
		OP_SUPPRESS = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now_tick;
		logic [31:0] newest_lap_tick;
		logic [31:0] previous_lap_tick;
		logic [2:0]  ring_index;
		logic [7:0]  slot_flags;
		logic [31:0] window_start;
		logic [31:0] window_end;
		logic [7:0]  substep_total;
		logic [7:0]  substep_number;
	} in_beat_t;

	typedef struct packed {
		logic        hold;
		logic        pressed;
		logic [4:0]  event_count;
		logic [31:0] head_tick;
		logic        head_down;
		logic        resynced;
	} out_beat_t;

	localparam logic [31:0] MAX_INTERVAL_RESET = 32'd26811185;
	localparam int SLOT_FLAG_BITS = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ICHK,
		ST_SDIV,
		ST_WALK,
		ST_MUL,
		ST_CDIV,
		ST_CUT,
		ST_RD,
		ST_DRAIN,
		ST_RESYNC,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic intv_ld;
		logic sdiv_start;
		logic cdiv_start;
		logic plan;
		logic walk_step;
		logic walk_done;
		logic mul;
		logic cut;
		logic rd;
		logic drain_step;
		logic resync;
		logic frame;
		logic suppress;
		logic rst_cmd;
		logic apply_init;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       div_done;
		logic       bad_interval;
		logic       walk_left;
		logic       overflow;
		logic       drain_go;
	} sts_t;

endpackage
`default_nettype wire

@@ sv/input_edge_timestamp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// input_edge_timestamp_queue
// ring sample edge extraction with a timestamped event queue
// ----------------------------------------------------------------------------
// channel   dir  handshake          beat
// in        in   in_valid/in_stall  in_beat_t command
// out       out  out_valid/out_stall out_beat_t status
// cfg       in   cfg_valid/cfg_ready max_interval
//
// one command at a time; a poll's result waits on the 41-bit serial division
// of elapsed ticks and then on the slot walk; a bad interval skips both.
// a substep waits on a multiply, a division and each released event;
// others go from decode straight to the result.
// reset clears the sequencer, queue pointers and source state; queue storage and latched command data are not cleared.
// result is held until out_stall is low; no new command is taken meanwhile.
// ----------------------------------------------------------------------------
module input_edge_timestamp_queue import ietq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_beat,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_beat,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	logic [31:0] max_interval_q;
	cmd_t        cmd;
	sts_t        sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_interval_q <= MAX_INTERVAL_RESET;
		else if (cfg_valid) max_interval_q <= cfg_data;
	end

	ietq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	ietq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .max_interval(max_interval_q),
		.cmd(cmd), .sts(sts), .out_beat(out_beat)
	);
endmodule
`default_nettype wire

@@ sv/ietq_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ietq_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ietq_div import ietq_pkg::*; #(
	parameter int W = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  rem_q, quo_q, dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q && !start;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ sv/ietq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ietq_ctrl
// command sequencer for poll, frame, substep, reset and suppress
// ----------------------------------------------------------------------------
module ietq_ctrl import ietq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.rd = 1'b1;
				unique case (sts.op)
					OP_POLL: begin
						cmd.intv_ld = 1'b1;
						state_d     = ST_ICHK;
					end
					OP_FRAME: begin
						cmd.frame = 1'b1;
						state_d   = ST_OUT;
					end
					OP_SUBSTEP: begin
						cmd.apply_init = 1'b1;
						cmd.mul        = 1'b1;
						state_d        = ST_MUL;
					end
					OP_RESET: begin
						cmd.resync  = 1'b1;
						cmd.rst_cmd = 1'b1;
						state_d     = ST_OUT;
					end
					OP_SUPPRESS: begin
						cmd.suppress = 1'b1;
						state_d      = ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_ICHK: begin
				if (sts.bad_interval) begin
					cmd.resync = 1'b1;
					state_d    = ST_OUT;
				end else begin
					cmd.sdiv_start = 1'b1;
					state_d        = ST_SDIV;
				end
			end
			ST_SDIV: begin
				if (sts.div_done) begin
					cmd.plan = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!sts.walk_left) begin
					cmd.walk_done = 1'b1;
					cmd.rd        = 1'b1;
					state_d       = ST_OUT;
				end else if (sts.overflow) begin
					cmd.resync = 1'b1;
					state_d    = ST_OUT;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.cdiv_start = 1'b1;
				state_d        = ST_CDIV;
			end
			ST_CDIV: begin
				if (sts.div_done) begin
					cmd.cut = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.drain_go) begin
					cmd.drain_step = 1'b1;
					state_d        = ST_RD;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/ietq_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ietq_dp
// ring walk, event queue, frame cutoff and source state
// ----------------------------------------------------------------------------
module ietq_dp import ietq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_beat_t    in_beat,
	input  wire logic [31:0] max_interval,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output out_beat_t        out_beat
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int RW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int AW = $clog2(RING_SLOTS + 1);
	localparam int SW = $clog2(RING_SLOTS);
	localparam int DW = 41;

	in_beat_t       it_q;
	logic [32:0]    mem [QUEUE_DEPTH];
	logic [32:0]    rd_q;
	logic [QW-1:0]  head_q;
	logic [OW-1:0]  occ_q;
	logic [RW-1:0]  seen_idx_q;
	logic [31:0]    seen_tick_q;
	logic           seen_lvl_q, held_q, supp_q, synth_q, edge_q, rs_q, pnow_q;
	logic [31:0]    fbeg_q, ffin_q;
	logic [7:0]     fsl_q;
	logic [31:0]    intv_q, cut_q;
	logic [AW-1:0]  left_q;
	logic [31:0]    etime_q;
	logic [39:0]    scaled_q;
	logic           final_q;

	logic           dstart;
	logic [DW-1:0]  dnd, dsr, quo;
	logic           ddone;

	ietq_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(dnd), .divisor(dsr), .done(ddone), .quotient(quo)
	);

	logic [RW-1:0] idx;
	logic [RW-1:0] adv;
	logic [RW-1:0] wslot;
	logic          lvl_idx, wlvl;
	logic [7:0]    slices;
	logic [QW-1:0] tail;
	logic [31:0]   dlt;
	logic [31:0]   wtick;
	logic [31:0]   lap_span;
	logic [31:0]   elapsed;
	logic [31:0]   span;

	function automatic logic flag_at(logic [7:0] f, logic [RW-1:0] s);
		logic r;
		r = 1'b0;
		if (32'(s) < 32'(SLOT_FLAG_BITS)) r = f[3'(s)];
		return r;
	endfunction

	assign idx      = RW'(32'(it_q.ring_index) % RING_SLOTS);
	assign adv      = RW'((32'(idx) + RING_SLOTS - 32'(seen_idx_q)) % RING_SLOTS);
	assign wslot    = RW'((32'(idx) + RING_SLOTS - (32'(left_q) - 1)) % RING_SLOTS);
	assign lvl_idx  = flag_at(it_q.slot_flags, idx);
	assign wlvl     = flag_at(it_q.slot_flags, wslot);
	assign slices   = (it_q.substep_total == 8'd0) ? 8'd1 : it_q.substep_total;
	assign tail     = QW'((32'(head_q) + 32'(occ_q)) % QUEUE_DEPTH);
	assign dlt      = rd_q[32:1] - cut_q;
	assign lap_span = it_q.newest_lap_tick - it_q.previous_lap_tick;
	assign elapsed  = it_q.now_tick - seen_tick_q;
	assign span     = ffin_q - fbeg_q;

	always_comb begin
		dstart = cmd.sdiv_start | cmd.cdiv_start;
		dnd    = '0;
		dsr    = DW'(1);
		if (cmd.sdiv_start) begin
			dnd = DW'({1'b0, elapsed} + {2'b0, intv_q[31:1]});
			dsr = DW'(intv_q);
		end else if (cmd.cdiv_start) begin
			dnd = DW'(scaled_q);
			dsr = DW'(fsl_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= in_beat;
		if (cmd.load) rs_q <= 1'b0;
		if (cmd.resync) rs_q <= 1'b1;
		if (cmd.intv_ld) intv_q <= lap_span >> SW;
		if (cmd.sdiv_start) etime_q <= it_q.newest_lap_tick + 32'(idx) * intv_q;
		if (cmd.plan) begin
			if (quo > DW'(RING_SLOTS)) left_q <= AW'(RING_SLOTS);
			else if (adv == '0 && quo >= DW'(RING_SLOTS / 2)) left_q <= AW'(RING_SLOTS);
			else left_q <= AW'(adv);
		end
		if (cmd.walk_step) left_q <= left_q - 1'b1;
		if (cmd.apply_init) final_q <= (9'(it_q.substep_number) + 9'd1) >= 9'(fsl_q);
		if (cmd.mul) scaled_q <= 40'(span) * 40'(9'(it_q.substep_number) + 9'd1);
		if (cmd.cut) cut_q <= fbeg_q + quo[31:0];
		if (cmd.rd) rd_q <= mem[head_q];
		if (cmd.walk_step && wlvl != seen_lvl_q && !sts.overflow) mem[tail] <= {wtick, wlvl};
	end

	assign wtick = etime_q - 32'(left_q - 1'b1) * intv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			occ_q       <= '0;
			seen_idx_q  <= '0;
			seen_tick_q <= '0;
			seen_lvl_q  <= 1'b0;
			held_q      <= 1'b0;
			supp_q      <= 1'b0;
			synth_q     <= 1'b0;
			edge_q      <= 1'b0;
			pnow_q      <= 1'b0;
			fbeg_q      <= '0;
			ffin_q      <= '0;
			fsl_q       <= 8'd1;
		end else begin
			if (cmd.frame) begin
				fbeg_q <= it_q.window_start;
				ffin_q <= it_q.window_end;
				fsl_q  <= slices;
			end
			if (cmd.suppress) supp_q <= 1'b1;
			if (cmd.walk_step) begin
				seen_lvl_q <= wlvl;
				if (wlvl != seen_lvl_q) occ_q <= occ_q + 1'b1;
			end
			if (cmd.walk_done) begin
				seen_idx_q  <= idx;
				seen_tick_q <= it_q.now_tick;
			end
			if (cmd.apply_init) begin
				edge_q  <= synth_q;
				synth_q <= 1'b0;
				pnow_q  <= 1'b0;
			end
			if (cmd.drain_step) begin
				head_q <= QW'((32'(head_q) + 1) % QUEUE_DEPTH);
				occ_q  <= occ_q - 1'b1;
				supp_q <= 1'b0;
				held_q <= rd_q[0];
				if (rd_q[0]) begin
					edge_q <= 1'b1;
					pnow_q <= 1'b1;
				end
			end
			if (cmd.resync) begin
				occ_q       <= '0;
				head_q      <= '0;
				seen_idx_q  <= idx;
				seen_tick_q <= it_q.now_tick;
				held_q      <= lvl_idx;
				seen_lvl_q  <= lvl_idx;
				if (!lvl_idx || cmd.rst_cmd) supp_q <= 1'b0;
				if (cmd.rst_cmd) begin
					synth_q <= 1'b0;
					edge_q  <= 1'b0;
				end else if (!held_q && lvl_idx && !supp_q) begin
					synth_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts.op           = it_q.op;
		sts.div_done     = ddone;
		sts.bad_interval = (intv_q == '0) || (intv_q > max_interval);
		sts.walk_left    = (left_q != '0);
		sts.overflow     = (wlvl != seen_lvl_q) && (32'(occ_q) >= QUEUE_DEPTH);
		sts.drain_go     = (occ_q != '0) && (final_q ||
			((dlt == '0 || dlt[31]) && !pnow_q));
	end

	always_comb begin
		out_beat.hold        = held_q && !supp_q;
		out_beat.pressed     = edge_q;
		out_beat.event_count = 5'(occ_q);
		out_beat.head_tick   = (occ_q != '0) ? rd_q[32:1] : '0;
		out_beat.head_down   = (occ_q != '0) ? rd_q[0] : 1'b0;
		out_beat.resynced    = rs_q;
	end
endmodule
`default_nettype wire
